[rtl/emi_pkg.sv]
package emi_pkg;

    typedef struct packed {
        logic               kind;
        logic        [31:0] time_stamp;
        logic signed [31:0] in_pos_x;
        logic signed [31:0] in_pos_y;
        logic signed [31:0] in_pos_z;
        logic signed [31:0] in_vel_x;
        logic signed [31:0] in_vel_y;
        logic signed [31:0] in_vel_z;
        logic signed [31:0] in_acc_x;
        logic signed [31:0] in_acc_y;
        logic signed [31:0] in_acc_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
        logic signed [31:0] out_vel_z;
        logic               stepped;
    } out_item_t;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE            = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_ACCELERATION  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_VELOCITY      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_FRICTION      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRICTION_FRACTION = 3'd4;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    // squared length below 0.001^2 in Q32 raw units
    localparam logic [63:0] SMALL_LIMIT = 64'd4295;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_WB   = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    typedef enum logic [2:0] {
        G_SQA = 3'd0,
        G_SQV = 3'd1,
        G_ACC = 3'd2,
        G_FRI = 3'd3,
        G_POS = 3'd4
    } grp_t;

endpackage

[rtl/emi_mul.sv]
module emi_mul (
    input  logic        aclk,
    input  logic [31:0] mul_a,
    input  logic [31:0] mul_b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    assign prod = prod_reg;

endmodule

[rtl/emi_scale.sv]
module emi_scale (
    input  logic [63:0]        prod,
    input  logic               neg,
    input  logic signed [31:0] addend,
    output logic signed [31:0] result
);

    logic [64:0]        rnd;
    logic [48:0]        mag;
    logic signed [49:0] sval;
    logic signed [50:0] total;

    always_comb begin
        rnd   = {1'b0, prod} + 65'h8000;
        mag   = rnd[64:16];
        sval  = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        total = $signed({sval[49], sval}) + $signed({{19{addend[31]}}, addend});
        if (total > 51'sd2147483647) begin
            result = 32'sh7FFFFFFF;
        end else if (total < -51'sd2147483648) begin
            result = 32'sh80000000;
        end else begin
            result = total[31:0];
        end
    end

endmodule

[rtl/euler_motion_integrator_3d.sv]
// channel   direction  handshake         payload
// s_        in         s_valid/s_ready   emi_pkg::in_item_t
// m_        out        m_valid/m_ready   emi_pkg::out_item_t
// cfg_      in         cfg_wr_en         cfg_index, cfg_wdata
// A load, an inactive tick or a first tick gives its result the cycle after accept.
// A stepping tick runs up to five groups of three lanes on one shared 32x32
// multiplier: each lane of an enabled group passes S_MUL then S_WB, a skipped
// group only S_MUL, then the result. s_ready is low until the result is taken.
// aresetn is synchronous; it sets active, leaves dt, neg, sum and clears the rest.
module euler_motion_integrator_3d (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  emi_pkg::in_item_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output emi_pkg::out_item_t                m_data,
    input  logic                              cfg_wr_en,
    input  logic [emi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [emi_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    emi_pkg::state_t    state_reg, state_next;
    emi_pkg::grp_t      group_reg, group_next, group_succ;
    logic [1:0]         lane_reg, lane_next;
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] pos_next [3];
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] vel_next [3];
    logic signed [31:0] acc_reg [3];
    logic signed [31:0] acc_next [3];
    logic [31:0]        last_time_reg, last_time_next;
    logic [31:0]        dt_reg, dt_next;
    logic               started_reg, started_next;
    logic               stepped_reg, stepped_next;
    logic               neg_reg, neg_next;
    logic [63:0]        sum_reg, sum_next;
    logic               active_reg, active_next;
    logic               use_acc_reg, use_acc_next;
    logic               use_vel_reg, use_vel_next;
    logic               use_fric_reg, use_fric_next;
    logic [15:0]        fric_reg, fric_next;

    logic               grp_en;
    logic signed [31:0] op_val;
    logic [31:0]        op_mag;
    logic [31:0]        mul_b;
    logic [31:0]        keep;
    logic signed [31:0] addend;
    logic [63:0]        prod;
    logic signed [31:0] scaled;

    assign keep   = 32'(17'h10000 - {1'b0, fric_reg});
    assign op_val = (group_reg == emi_pkg::G_SQA || group_reg == emi_pkg::G_ACC)
                    ? acc_reg[lane_reg] : vel_reg[lane_reg];
    assign op_mag = op_val[31] ? 32'(-op_val) : 32'(op_val);

    always_comb begin
        case (group_reg)
            emi_pkg::G_SQA: begin
                grp_en = use_acc_reg;  mul_b = op_mag; addend = '0;
                group_succ = emi_pkg::G_SQV;
            end
            emi_pkg::G_SQV: begin
                grp_en = use_vel_reg;  mul_b = op_mag; addend = '0;
                group_succ = emi_pkg::G_ACC;
            end
            emi_pkg::G_ACC: begin
                grp_en = use_acc_reg;  mul_b = dt_reg; addend = vel_reg[lane_reg];
                group_succ = emi_pkg::G_FRI;
            end
            emi_pkg::G_FRI: begin
                grp_en = use_fric_reg && (fric_reg != 16'd0);
                mul_b = keep; addend = '0;
                group_succ = emi_pkg::G_POS;
            end
            emi_pkg::G_POS: begin
                grp_en = use_vel_reg;  mul_b = dt_reg; addend = pos_reg[lane_reg];
                group_succ = emi_pkg::G_POS;
            end
            default: begin
                grp_en = 1'b0; mul_b = '0; addend = '0;
                group_succ = emi_pkg::G_POS;
            end
        endcase
    end

    emi_mul u_mul (
        .aclk  (aclk),
        .mul_a (op_mag),
        .mul_b (mul_b),
        .prod  (prod)
    );

    emi_scale u_scale (
        .prod   (prod),
        .neg    (neg_reg),
        .addend (addend),
        .result (scaled)
    );

    always_comb begin
        state_next     = state_reg;
        group_next     = group_reg;
        lane_next      = lane_reg;
        pos_next       = pos_reg;
        vel_next       = vel_reg;
        acc_next       = acc_reg;
        last_time_next = last_time_reg;
        dt_next        = dt_reg;
        started_next   = started_reg;
        stepped_next   = stepped_reg;
        neg_next       = neg_reg;
        sum_next       = sum_reg;
        active_next    = active_reg;
        use_acc_next   = use_acc_reg;
        use_vel_next   = use_vel_reg;
        use_fric_next  = use_fric_reg;
        fric_next      = fric_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                emi_pkg::CFG_ACTIVE:            active_next   = cfg_wdata[0];
                emi_pkg::CFG_USE_ACCELERATION:  use_acc_next  = cfg_wdata[0];
                emi_pkg::CFG_USE_VELOCITY:      use_vel_next  = cfg_wdata[0];
                emi_pkg::CFG_USE_FRICTION:      use_fric_next = cfg_wdata[0];
                emi_pkg::CFG_FRICTION_FRACTION: fric_next     = cfg_wdata;
                default: ;
            endcase
        end

        case (state_reg)
            emi_pkg::S_IDLE: begin
                if (s_valid) begin
                    stepped_next = 1'b0;
                    state_next   = emi_pkg::S_OUT;
                    if (s_data.kind == emi_pkg::KIND_LOAD) begin
                        pos_next[0] = s_data.in_pos_x;
                        pos_next[1] = s_data.in_pos_y;
                        pos_next[2] = s_data.in_pos_z;
                        vel_next[0] = s_data.in_vel_x;
                        vel_next[1] = s_data.in_vel_y;
                        vel_next[2] = s_data.in_vel_z;
                        acc_next[0] = s_data.in_acc_x;
                        acc_next[1] = s_data.in_acc_y;
                        acc_next[2] = s_data.in_acc_z;
                    end else if (active_reg) begin
                        last_time_next = s_data.time_stamp;
                        if (!started_reg) begin
                            started_next = 1'b1;
                        end else begin
                            dt_next      = s_data.time_stamp - last_time_reg;
                            stepped_next = 1'b1;
                            group_next   = emi_pkg::G_SQA;
                            lane_next    = 2'd0;
                            state_next   = emi_pkg::S_MUL;
                        end
                    end
                end
            end
            emi_pkg::S_MUL: begin
                if (grp_en) begin
                    neg_next   = op_val[31];
                    state_next = emi_pkg::S_WB;
                end else begin
                    lane_next = 2'd0;
                    if (group_reg == emi_pkg::G_POS) begin
                        state_next = emi_pkg::S_OUT;
                    end else begin
                        group_next = group_succ;
                    end
                end
            end
            emi_pkg::S_WB: begin
                case (group_reg)
                    emi_pkg::G_SQA, emi_pkg::G_SQV: begin
                        sum_next = (lane_reg == 2'd0) ? prod : sum_reg + prod;
                        if (lane_reg == 2'd2 && sum_next < emi_pkg::SMALL_LIMIT) begin
                            if (group_reg == emi_pkg::G_SQA) begin
                                acc_next = '{default: '0};
                            end else begin
                                vel_next = '{default: '0};
                            end
                        end
                    end
                    emi_pkg::G_ACC, emi_pkg::G_FRI: vel_next[lane_reg] = scaled;
                    emi_pkg::G_POS:                 pos_next[lane_reg] = scaled;
                    default: ;
                endcase
                state_next = emi_pkg::S_MUL;
                if (lane_reg == 2'd2) begin
                    lane_next = 2'd0;
                    if (group_reg == emi_pkg::G_POS) begin
                        state_next = emi_pkg::S_OUT;
                    end else begin
                        group_next = group_succ;
                    end
                end else begin
                    lane_next = lane_reg + 2'd1;
                end
            end
            emi_pkg::S_OUT: begin
                if (m_ready) begin
                    state_next = emi_pkg::S_IDLE;
                end
            end
            default: state_next = emi_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= emi_pkg::S_IDLE;
            group_reg     <= emi_pkg::G_SQA;
            lane_reg      <= 2'd0;
            pos_reg       <= '{default: '0};
            vel_reg       <= '{default: '0};
            acc_reg       <= '{default: '0};
            last_time_reg <= '0;
            started_reg   <= 1'b0;
            stepped_reg   <= 1'b0;
            active_reg    <= 1'b1;
            use_acc_reg   <= 1'b0;
            use_vel_reg   <= 1'b0;
            use_fric_reg  <= 1'b0;
            fric_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            group_reg     <= group_next;
            lane_reg      <= lane_next;
            pos_reg       <= pos_next;
            vel_reg       <= vel_next;
            acc_reg       <= acc_next;
            last_time_reg <= last_time_next;
            started_reg   <= started_next;
            stepped_reg   <= stepped_next;
            active_reg    <= active_next;
            use_acc_reg   <= use_acc_next;
            use_vel_reg   <= use_vel_next;
            use_fric_reg  <= use_fric_next;
            fric_reg      <= fric_next;
        end
    end

    always_ff @(posedge aclk) begin
        dt_reg  <= dt_next;
        neg_reg <= neg_next;
        sum_reg <= sum_next;
    end

    assign s_ready = (state_reg == emi_pkg::S_IDLE);
    assign m_valid = (state_reg == emi_pkg::S_OUT);

    always_comb begin
        m_data.out_pos_x = pos_reg[0];
        m_data.out_pos_y = pos_reg[1];
        m_data.out_pos_z = pos_reg[2];
        m_data.out_vel_x = vel_reg[0];
        m_data.out_vel_y = vel_reg[1];
        m_data.out_vel_z = vel_reg[2];
        m_data.stepped   = stepped_reg;
    end

endmodule
